// ===== hw/rtl/tojq_pkg.sv =====
// Shared types and codes for the time-ordered job queue.
`timescale 1ns / 1ps
package tojq_pkg;

    // Request codes as they arrive on the kind field
    localparam logic [1:0] KIND_SCHED = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_DEL   = 2'd2;

    typedef enum logic [1:0] {
        OP_SCHED,
        OP_POP,
        OP_DEL,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_NOT_FOUND,
        ST_EMPTY
    } t_status;

    typedef enum logic {
        BK_IDLE,
        BK_APPLY
    } t_back_state;

    typedef struct packed {
        t_op         op;
        logic [15:0] job_id;
        logic [31:0] due_time;
        logic [15:0] cmd;
    } t_item;

    // Handshake between the command queue and its neighbours
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

// ===== hw/rtl/tojq_front.sv =====
// Front end: takes requests, decodes the kind and hands them to the command queue.
`timescale 1ns / 1ps
module tojq_front import tojq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [1:0]   i_kind,
    input  logic [15:0]  i_job_id,
    input  logic [31:0]  i_due_time,
    input  logic [15:0]  i_command_handle,
    input  t_fifo_status i_fifo_status,
    output logic         o_push,
    output t_item        o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_op   dec_op;

    always_comb begin
        case (i_kind)
            KIND_SCHED: dec_op = OP_SCHED;
            KIND_POP:   dec_op = OP_POP;
            KIND_DEL:   dec_op = OP_DEL;
            default:    dec_op = OP_NOP;
        endcase
    end

    assign busy   = r_valid && i_fifo_status.full;
    assign o_push = r_valid && !i_fifo_status.full;
    assign o_item = r_item;

    always_comb begin
        n_valid = r_valid;
        if (start && !busy) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_item.op       <= dec_op;
            r_item.job_id   <= i_job_id;
            r_item.due_time <= i_due_time;
            r_item.cmd      <= i_command_handle;
        end
    end

endmodule

// ===== hw/rtl/tojq_fifo.sv =====
// Two-entry command queue between front end and execution unit.
`timescale 1ns / 1ps
module tojq_fifo import tojq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_item        i_item,
    input  logic         i_pop,
    output t_item        o_item,
    output t_fifo_status o_status
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic [1:0] n_fill;

    assign o_status.full  = (r_fill == 2'd2);
    assign o_status.empty = (r_fill == 2'd0);
    assign o_item         = r_mem[r_rd_ptr];

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/tojq_back.sv =====
// Execution unit: sorted cell chain that inserts, pops and deletes jobs.
`timescale 1ns / 1ps
module tojq_back import tojq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_item        i_item,
    input  t_fifo_status i_fifo_status,
    output logic         o_pop,
    output logic         o_valid,
    output logic [1:0]   o_status,
    output logic [15:0]  o_out_job_id,
    output logic [31:0]  o_out_due_time,
    output logic [15:0]  o_out_command,
    output logic [4:0]   o_occupancy
);

    localparam int N  = QUEUE_DEPTH;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_back_state r_state;
    t_back_state n_state;
    t_item       r_item;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [N-1:0]  r_lt;
    logic [N-1:0]  n_lt;
    logic [N-1:0]  r_match;
    logic [N-1:0]  n_match;
    logic [N-1:0]  pre_match;

    logic [15:0] r_ids   [N];
    logic [31:0] r_times [N];
    logic [15:0] r_cmds  [N];
    logic [15:0] n_ids   [N];
    logic [31:0] n_times [N];
    logic [15:0] n_cmds  [N];

    logic        r_res_valid;
    logic        n_res_valid;
    t_status     r_res_status;
    t_status     n_res_status;
    logic [15:0] r_res_id;
    logic [15:0] n_res_id;
    logic [31:0] r_res_time;
    logic [31:0] n_res_time;
    logic [15:0] r_res_cmd;
    logic [15:0] n_res_cmd;
    logic [CW+4:0] occ_ext;

    logic is_full;
    logic is_empty;

    assign is_full  = (r_count == CW'(QUEUE_DEPTH));
    assign is_empty = (r_count == '0);
    assign o_pop    = (r_state == BK_IDLE) && !i_fifo_status.empty;

    // Compare the incoming job against every live cell in parallel
    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_lt[i]    = (CW'(i) < r_count) && (r_times[i] < i_item.due_time);
            n_match[i] = (CW'(i) < r_count) && (r_ids[i] == i_item.job_id);
        end
    end

    // Log-depth prefix OR: every cell at or past the first hit shifts down
    always_comb begin
        pre_match = r_match;
        for (int d = 1; d < N; d = d * 2) begin
            for (int i = N - 1; i >= d; i--) begin
                pre_match[i] = pre_match[i] | pre_match[i-d];
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ids        = r_ids;
        n_times      = r_times;
        n_cmds       = r_cmds;
        n_res_valid  = 1'b0;
        n_res_status = ST_OK;
        n_res_id     = '0;
        n_res_time   = '0;
        n_res_cmd    = '0;
        case (r_state)
            BK_IDLE: begin
                if (o_pop) begin
                    n_state = BK_APPLY;
                end
            end
            BK_APPLY: begin
                n_state     = BK_IDLE;
                n_res_valid = 1'b1;
                case (r_item.op)
                    OP_SCHED: begin
                        if (is_full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            for (int i = 0; i < N; i++) begin
                                if (!r_lt[i]) begin
                                    if (i == 0 || r_lt[(i > 0) ? i - 1 : 0]) begin
                                        n_ids[i]   = r_item.job_id;
                                        n_times[i] = r_item.due_time;
                                        n_cmds[i]  = r_item.cmd;
                                    end else begin
                                        n_ids[i]   = r_ids[(i > 0) ? i - 1 : 0];
                                        n_times[i] = r_times[(i > 0) ? i - 1 : 0];
                                        n_cmds[i]  = r_cmds[(i > 0) ? i - 1 : 0];
                                    end
                                end
                            end
                            n_count = r_count + CW'(1);
                        end
                    end
                    OP_POP: begin
                        if (is_empty) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            n_res_id   = r_ids[0];
                            n_res_time = r_times[0];
                            n_res_cmd  = r_cmds[0];
                            for (int i = 0; i < N - 1; i++) begin
                                n_ids[i]   = r_ids[i+1];
                                n_times[i] = r_times[i+1];
                                n_cmds[i]  = r_cmds[i+1];
                            end
                            n_count = r_count - CW'(1);
                        end
                    end
                    OP_DEL: begin
                        if (!(|r_match)) begin
                            n_res_status = ST_NOT_FOUND;
                        end else begin
                            for (int i = 0; i < N - 1; i++) begin
                                if (pre_match[i]) begin
                                    n_ids[i]   = r_ids[i+1];
                                    n_times[i] = r_times[i+1];
                                    n_cmds[i]  = r_cmds[i+1];
                                end
                            end
                            n_count = r_count - CW'(1);
                        end
                    end
                    default: begin
                        n_res_status = ST_OK;
                    end
                endcase
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item  <= i_item;
            r_lt    <= n_lt;
            r_match <= n_match;
        end
        r_ids        <= n_ids;
        r_times      <= n_times;
        r_cmds       <= n_cmds;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_time   <= n_res_time;
        r_res_cmd    <= n_res_cmd;
    end

    assign occ_ext        = {5'b0, r_count};
    assign o_valid        = r_res_valid;
    assign o_status       = r_res_status;
    assign o_out_job_id   = r_res_id;
    assign o_out_due_time = r_res_time;
    assign o_out_command  = r_res_cmd;
    assign o_occupancy    = occ_ext[4:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("job count beyond depth");

    a_result_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_APPLY) |=> (r_res_valid && r_state == BK_IDLE))
        else $error("result not issued after apply");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE) |=> (r_count == $past(r_count)))
        else $error("count changed outside apply");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res_status != ST_OK)
            |-> (r_res_id == '0 && r_res_time == '0 && r_res_cmd == '0))
        else $error("job fields set on failed request");

endmodule

// ===== hw/rtl/time_ordered_job_queue.sv =====
// Top level of the time-ordered job queue.
`timescale 1ns / 1ps
// Holds up to QUEUE_DEPTH jobs sorted by ascending due time in a chain of cells; a
// new job goes ahead of queued jobs with an equal or later time. A request is taken
// when start is high and busy is low; the front end registers it and passes it
// through a two-entry command queue to the execution unit, which, while idle,
// compares each request against every cell and registers the outcome, then shifts
// the chain in its apply state; it takes no new request from the queue until it is
// through with the last one. o_valid comes from a result register set in the apply
// state (so it rises later while earlier requests wait ahead) and marks the result
// for exactly one cycle; it cannot be held off, so the receiver must take it then.
// busy rises only while the front register and the command queue are all full.
module time_ordered_job_queue import tojq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_job_id,
    input  logic [31:0] i_due_time,
    input  logic [15:0] i_command_handle,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_job_id,
    output logic [31:0] o_out_due_time,
    output logic [15:0] o_out_command,
    output logic [4:0]  o_occupancy
);

    t_fifo_status fifo_status;
    t_item        front_item;
    t_item        head_item;
    logic         push;
    logic         pop;

    tojq_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_job_id         (i_job_id),
        .i_due_time       (i_due_time),
        .i_command_handle (i_command_handle),
        .i_fifo_status    (fifo_status),
        .o_push           (push),
        .o_item           (front_item)
    );

    tojq_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (fifo_status)
    );

    tojq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (head_item),
        .i_fifo_status  (fifo_status),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_job_id   (o_out_job_id),
        .o_out_due_time (o_out_due_time),
        .o_out_command  (o_out_command),
        .o_occupancy    (o_occupancy)
    );

endmodule
